// File: rtl/core/regex_literal_delimiter_scanner_assert.svh
// assertion macros for the scanner rtl
`ifndef REGEX_LITERAL_DELIMITER_SCANNER_ASSERT_SVH
`define REGEX_LITERAL_DELIMITER_SCANNER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RLDS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rlds assertion failed");

// next-cycle implication, disabled in reset
`define RLDS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rlds assertion failed");

`endif

// File: rtl/core/rlds_pkg.sv
// types, constants and codes for the regex literal delimiter scanner
package rlds_pkg;

   localparam int MAX_HASHES  = 15;
   localparam int OFFSET_BITS = 16;
   localparam int OPEN_BITS   = $clog2(MAX_HASHES + 1);
   localparam int CLOSE_BITS  = $clog2(MAX_HASHES + 2);

   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NUL    = 8'h00;

   // utf-8 tracker codes, any other value is the held lead byte
   localparam logic [7:0] U_OK   = 8'd0;
   localparam logic [7:0] U_BAD  = 8'd1;
   localparam logic [7:0] U_SKIP = 8'd2;

   localparam logic [7:0] LEAD_E0 = 8'hE0;
   localparam logic [7:0] LEAD_ED = 8'hED;
   localparam logic [7:0] LEAD_F0 = 8'hF0;

   typedef enum logic [2:0] {
      PH_LEAD  = 3'd0,
      PH_WS    = 3'd1,
      PH_BODY  = 3'd2,
      PH_CLOSE = 3'd3,
      PH_DONE  = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      ST_SCAN     = 3'd0,
      ST_NOTREGEX = 3'd1,
      ST_CLOSED   = 3'd2,
      ST_NEWLINE  = 3'd3,
      ST_EOF      = 3'd4,
      ST_TOOLONG  = 3'd5
   } status_type;

   typedef struct packed {
      phase_type              phase;
      logic [OPEN_BITS-1:0]   open_hashes;
      logic [CLOSE_BITS-1:0]  close_hashes;
      logic                   multiline_flag;
      logic                   newline_seen;
      logic [OFFSET_BITS-1:0] first_newline_offset;
      logic [OFFSET_BITS-1:0] position;
      logic                   escape_pending;
      logic [1:0]             utf8_remaining;
      logic [7:0]             utf8_lead_info;
   } state_type;

   typedef struct packed {
      status_type             status;
      logic [OFFSET_BITS-1:0] resume_offset;
      logic                   utf8_error;
      logic                   multiline_mode;
   } result_type;

   localparam state_type RESET_STATE = '{
      phase:                PH_LEAD,
      open_hashes:          '0,
      close_hashes:         '0,
      multiline_flag:       1'b0,
      newline_seen:         1'b0,
      first_newline_offset: '0,
      position:             '0,
      escape_pending:       1'b0,
      utf8_remaining:       2'd0,
      utf8_lead_info:       U_OK
   };

endpackage

// File: rtl/core/rlds_if.sv
// valid/ready channel interfaces for request and response beats
interface rlds_req_if;
   logic       valid;
   logic       ready;
   logic       start_req;
   logic [7:0] byte_value;
   logic       at_end;

   modport source (output valid, output start_req, output byte_value, output at_end,
                   input ready);
   modport sink   (input valid, input start_req, input byte_value, input at_end,
                   output ready);
endinterface

interface rlds_rsp_if;
   import rlds_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [2:0]             status;
   logic [OFFSET_BITS-1:0] resume_offset;
   logic                   utf8_error;
   logic                   multiline_mode;

   modport source (output valid, output status, output resume_offset, output utf8_error,
                   output multiline_mode, input ready);
   modport sink   (input valid, input status, input resume_offset, input utf8_error,
                   input multiline_mode, output ready);
endinterface

// File: rtl/core/rlds_step.sv
// next-state and result logic for one byte of the scan
module rlds_step (
   input  rlds_pkg::state_type  cur_state,
   input  logic                 start_req,
   input  logic [7:0]           byte_value,
   input  logic                 at_end,
   output rlds_pkg::state_type  nxt_state,
   output rlds_pkg::result_type result
);
   import rlds_pkg::*;

   state_type              s;
   status_type             st;
   logic [OFFSET_BITS-1:0] off;
   logic                   uerr;
   logic                   cont;
   logic                   is_nl;
   logic                   done;
   logic                   begin_utf8;
   logic                   bad;

   assign cont  = (byte_value[7:6] == 2'b10);
   assign is_nl = (byte_value == CH_CR) || (byte_value == CH_LF);

   always_comb begin
      s          = start_req ? RESET_STATE : cur_state;
      st         = ST_SCAN;
      off        = '0;
      uerr       = 1'b0;
      done       = 1'b0;
      begin_utf8 = 1'b0;
      bad        = 1'b0;

      if (s.phase == PH_DONE) begin
         // idle until the next start
      end else if (at_end) begin
         if (s.phase == PH_LEAD) begin
            st = ST_NOTREGEX;
         end else begin
            uerr             = (s.utf8_remaining != 2'd0);
            s.utf8_remaining = 2'd0;
            s.utf8_lead_info = U_OK;
            s.escape_pending = 1'b0;
            if (s.phase == PH_CLOSE
                && s.close_hashes == CLOSE_BITS'(s.open_hashes)) begin
               st  = ST_CLOSED;
               off = s.position;
            end else begin
               st  = ST_EOF;
               off = s.newline_seen ? s.first_newline_offset : s.position;
            end
         end
      end else begin
         if (s.phase == PH_LEAD) begin
            if (byte_value == CH_HASH) begin
               if (s.open_hashes == OPEN_BITS'(MAX_HASHES)) begin
                  st = ST_TOOLONG;
               end else begin
                  s.open_hashes = s.open_hashes + OPEN_BITS'(1);
               end
            end else if (byte_value == CH_SLASH) begin
               s.phase = (s.open_hashes != '0) ? PH_WS : PH_BODY;
            end else begin
               st = ST_NOTREGEX;
            end
         end else if (s.phase == PH_WS
                      && (byte_value == CH_SPACE || byte_value == CH_TAB)) begin
            // whitespace after the opening delimiter
         end else if (s.phase == PH_WS && is_nl) begin
            s.multiline_flag       = 1'b1;
            s.newline_seen         = 1'b1;
            s.first_newline_offset = s.position;
            s.phase                = PH_BODY;
         end else begin
            if (s.phase == PH_WS) begin
               s.phase = PH_BODY;
            end
            // stray continuation bytes
            if (s.utf8_remaining == 2'd0 && s.utf8_lead_info == U_SKIP) begin
               if (cont) begin
                  done = 1'b1;
               end else begin
                  s.utf8_lead_info = U_OK;
               end
            end
            // open multi-byte sequence
            if (!done && s.utf8_remaining != 2'd0) begin
               if (cont) begin
                  if (s.utf8_lead_info >= 8'hC0) begin
                     bad = (s.utf8_lead_info == LEAD_E0 && byte_value < 8'hA0)
                        || (s.utf8_lead_info == LEAD_ED && byte_value >= 8'hA0)
                        || (s.utf8_lead_info == LEAD_F0 && byte_value < 8'h90);
                     s.utf8_lead_info = bad ? U_BAD : U_OK;
                  end
                  s.utf8_remaining = s.utf8_remaining - 2'd1;
                  if (s.utf8_remaining == 2'd0) begin
                     if (s.utf8_lead_info == U_BAD) begin
                        uerr = 1'b1;
                     end
                     s.utf8_lead_info = U_OK;
                  end
                  done = 1'b1;
               end else begin
                  uerr             = 1'b1;
                  s.utf8_remaining = 2'd0;
                  s.utf8_lead_info = U_OK;
               end
            end
            // escaped character
            if (!done && s.escape_pending) begin
               s.escape_pending = 1'b0;
               done             = 1'b1;
               if (!s.multiline_flag && is_nl) begin
                  st  = ST_NEWLINE;
                  off = s.position - OFFSET_BITS'(1);
               end else begin
                  begin_utf8 = 1'b1;
               end
            end
            // closing hash run
            if (!done && s.phase == PH_CLOSE) begin
               if (byte_value == CH_HASH) begin
                  s.close_hashes = s.close_hashes + CLOSE_BITS'(1);
                  if (s.close_hashes > CLOSE_BITS'(s.open_hashes)) begin
                     s.phase = PH_BODY;
                  end
                  done = 1'b1;
               end else if (s.close_hashes == CLOSE_BITS'(s.open_hashes)) begin
                  st   = ST_CLOSED;
                  off  = s.position;
                  done = 1'b1;
               end else begin
                  s.phase = PH_BODY;
               end
            end
            if (!done) begin
               unique case (byte_value)
                  CH_CR, CH_LF: begin
                     if (!s.multiline_flag) begin
                        st  = ST_NEWLINE;
                        off = s.position;
                     end
                  end
                  CH_BSLASH: begin
                     s.escape_pending = 1'b1;
                  end
                  CH_SLASH: begin
                     if (s.open_hashes == '0) begin
                        st  = ST_CLOSED;
                        off = s.position + OFFSET_BITS'(1);
                     end else begin
                        s.phase        = PH_CLOSE;
                        s.close_hashes = '0;
                     end
                  end
                  CH_NUL: begin
                  end
                  default: begin
                     begin_utf8 = 1'b1;
                  end
               endcase
            end
            // start of a new utf-8 sequence
            if (begin_utf8 && byte_value[7]) begin
               if (byte_value < 8'hC0) begin
                  uerr             = 1'b1;
                  s.utf8_lead_info = U_SKIP;
               end else if (byte_value < 8'hE0) begin
                  s.utf8_remaining = 2'd1;
                  s.utf8_lead_info = byte_value;
               end else if (byte_value < 8'hF0) begin
                  s.utf8_remaining = 2'd2;
                  s.utf8_lead_info = byte_value;
               end else if (byte_value < 8'hF8) begin
                  s.utf8_remaining = 2'd3;
                  s.utf8_lead_info = byte_value;
               end else begin
                  uerr = 1'b1;
               end
            end
         end
         s.position = s.position + OFFSET_BITS'(1);
      end

      if (st != ST_SCAN) begin
         s.phase = PH_DONE;
      end

      nxt_state             = s;
      result.status         = st;
      result.resume_offset  = off;
      result.utf8_error     = uerr;
      result.multiline_mode = s.multiline_flag;
   end

endmodule

// File: rtl/core/regex_literal_delimiter_scanner.sv
// top level of the regex literal delimiter scanner
//
// req_ch carries one source byte per beat (start_req opens a new scan at
// offset 0, at_end marks the end of the buffer with no byte). rsp_ch returns
// exactly one result beat for every request beat, in order: status,
// resume_offset, utf8_error and multiline_mode.
// The result of a request beat is registered when the beat is accepted and is
// presented on rsp_ch from the next cycle. Throughput is one beat per cycle
// while rsp_ch is not stalled; the scan state register and the result register
// are updated by a single pass of next-state logic per byte.
// The result register doubles as the output stage: req_ch.ready is high when
// it is empty or being emptied in the same cycle, so a stalled receiver
// holds the current result and stops new request beats, with no loss.
// Synchronous reset clears the scan state to the leading-hash phase at offset
// zero and drops rsp_ch.valid; req_ch.ready is low while reset is asserted.
// After a final status further bytes give status zero until the next start.
module regex_literal_delimiter_scanner (
   input logic        clock,
   input logic        reset,
   rlds_req_if.sink   req_ch,
   rlds_rsp_if.source rsp_ch
);
   import rlds_pkg::*;

`include "regex_literal_delimiter_scanner_assert.svh"

   state_type  state_ff;
   state_type  state_in;
   result_type step_result;
   result_type result_ff;
   logic       rsp_valid_ff;
   logic       req_fire;

   rlds_step u_step (
      .cur_state  (state_ff),
      .start_req  (req_ch.start_req),
      .byte_value (req_ch.byte_value),
      .at_end     (req_ch.at_end),
      .nxt_state  (state_in),
      .result     (step_result)
   );

   assign req_ch.ready = !reset && (!rsp_valid_ff || rsp_ch.ready);
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= RESET_STATE;
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         result_ff <= step_result;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = result_ff.status;
   assign rsp_ch.resume_offset  = result_ff.resume_offset;
   assign rsp_ch.utf8_error     = result_ff.utf8_error;
   assign rsp_ch.multiline_mode = result_ff.multiline_mode;

   `RLDS_ASSERT_NXT(a_final_ends_scan, clock, reset,
      req_fire && step_result.status != ST_SCAN, state_ff.phase == PH_DONE)
   `RLDS_ASSERT_NXT(a_done_stays_quiet, clock, reset,
      req_fire && !req_ch.start_req && state_ff.phase == PH_DONE,
      rsp_ch.status == ST_SCAN && !rsp_ch.utf8_error)
   `RLDS_ASSERT_IMP(a_scan_offset_zero, clock, reset,
      rsp_valid_ff && result_ff.status == ST_SCAN, result_ff.resume_offset == '0)
   `RLDS_ASSERT_NXT(a_multiline_sticky, clock, reset,
      req_fire && !req_ch.start_req && state_ff.multiline_flag,
      state_ff.multiline_flag && rsp_ch.multiline_mode)

endmodule
